/* rtl/rsdf_pkg.sv */
// shared types and constants for the dual frame deframer
package rsdf_pkg;

   localparam logic [7:0]  DISP_SYNC0      = 8'hAA;
   localparam logic [7:0]  DISP_SYNC1      = 8'h55;
   localparam logic [7:0]  CAM_SYNC0       = 8'h40;
   localparam logic [7:0]  CAM_SYNC2       = 8'h63;
   localparam logic [15:0] MAX_CAM_LEN_RST = 16'd600;
   localparam int          QUEUE_DEPTH_DEF = 4;

   localparam logic KIND_DISPLAY = 1'b0;
   localparam logic KIND_CAMERA  = 1'b1;

   typedef enum logic {
      CMD_SINGLE   = 1'b0,
      CMD_DISP_HDR = 1'b1
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic       frame_kind;
      logic [7:0] data;
      logic       last;
      logic       empty;
   } cmd_type;

endpackage

/* rtl/rs485_dual_frame_deframer.sv */
// top level of the dual frame deframer: parser, command queue, output sequencer
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_rx_byte
//   rsp      out        rsp_valid/rsp_stall   rsp_frame_kind, rsp_out_byte,
//                                             rsp_last_byte, rsp_empty_frame
//   csr      in         csr_write_en          csr_write_data (max camera length)
//
// one byte is taken per cycle while the command queue has room; a word at the
// queue head is registered out when the output register is empty or not stalled.
// a display header byte yields three words, sync0, sync1 and length, sent in turn
// by the output sequencer; every other byte yields at most one word per cycle.
// req_stall rises only when the queue is full; rsp_stall holds the output
// register and, through the queue, eventually the input.
// synchronous reset returns to header hunt and loads max camera length 600.
module rs485_dual_frame_deframer #(
   parameter int QueueDepth = rsdf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_frame_kind,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_byte,
   output logic        rsp_empty_frame,
   input  logic        csr_write_en,
   input  logic [15:0] csr_write_data
);
   import rsdf_pkg::*;

   cmd_type push_cmd, head_cmd;
   logic    push, pop, q_full, q_empty;

   rsdf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .q_full         (q_full),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   rsdf_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   rsdf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .head_cmd        (head_cmd),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_kind  (rsp_frame_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_byte   (rsp_last_byte),
      .rsp_empty_frame (rsp_empty_frame)
   );

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

   a_empty_marker_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_frame |->
         rsp_last_byte && rsp_frame_kind == KIND_CAMERA && rsp_out_byte == 8'h00)
      else $error("malformed empty frame marker");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push && q_full |-> !(req_valid && !req_stall))
      else $error("command pushed into a full queue");

endmodule

/* rtl/rsdf_front.sv */
// header hunt and frame tracking, one byte per cycle unless queue is full
module rsdf_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_rx_byte,
   input  logic             csr_write_en,
   input  logic [15:0]      csr_write_data,
   input  logic             q_full,
   output logic             push,
   output rsdf_pkg::cmd_type push_cmd
);
   import rsdf_pkg::*;

   typedef enum logic [2:0] {
      MODE_HUNT = 3'b001,
      MODE_DISP = 3'b010,
      MODE_CAM  = 3'b100
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  second_ff, second_in;
   logic [7:0]  third_ff, third_in;
   logic [7:0]  len_low_ff, len_low_in;
   logic [15:0] frame_len_ff, frame_len_in;
   logic [15:0] max_len_ff, max_len_in;
   logic        accept;
   logic [15:0] count_inc;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign count_inc = count_ff + 16'd1;

   always_comb begin
      mode_in      = mode_ff;
      count_in     = count_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      third_in     = third_ff;
      len_low_in   = len_low_ff;
      frame_len_in = frame_len_ff;
      max_len_in   = csr_write_en ? csr_write_data : max_len_ff;
      push         = 1'b0;
      push_cmd.op         = CMD_SINGLE;
      push_cmd.frame_kind = KIND_DISPLAY;
      push_cmd.data       = req_rx_byte;
      push_cmd.last       = 1'b0;
      push_cmd.empty      = 1'b0;
      if (accept) begin
         count_in = count_inc;
         case (mode_ff)
            MODE_HUNT: begin
               case (count_inc)
                  16'd1: begin
                     first_in = req_rx_byte;
                     if (req_rx_byte != DISP_SYNC0 && req_rx_byte != CAM_SYNC0) begin
                        count_in = '0;
                     end
                  end
                  16'd2: begin
                     second_in = req_rx_byte;
                     if (req_rx_byte != DISP_SYNC1 && req_rx_byte != CAM_SYNC0) begin
                        count_in = '0;
                     end
                  end
                  16'd3: begin
                     third_in = req_rx_byte;
                     if (first_ff == DISP_SYNC0 && second_ff == DISP_SYNC1) begin
                        frame_len_in = {8'h00, req_rx_byte};
                        mode_in      = MODE_DISP;
                        push         = 1'b1;
                        push_cmd.op  = CMD_DISP_HDR;
                     end else if (first_ff != CAM_SYNC0) begin
                        count_in = '0;
                     end
                  end
                  16'd6: begin
                     len_low_in = req_rx_byte;
                  end
                  16'd7: begin
                     frame_len_in = {req_rx_byte, len_low_ff};
                  end
                  16'd8: begin
                     // header complete: accept only a sane camera header
                     count_in = '0;
                     if (first_ff == CAM_SYNC0 && second_ff == CAM_SYNC0 &&
                         third_ff == CAM_SYNC2 && frame_len_ff <= max_len_ff) begin
                        mode_in = MODE_CAM;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            MODE_DISP: begin
               push = 1'b1;
               if ({1'b0, count_inc} >= ({1'b0, frame_len_ff} + 17'd3)) begin
                  push_cmd.last = 1'b1;
                  mode_in       = MODE_HUNT;
                  count_in      = '0;
               end
            end
            MODE_CAM: begin
               push                = 1'b1;
               push_cmd.frame_kind = KIND_CAMERA;
               if (frame_len_ff == 16'd0) begin
                  // zero length: swallow one byte, send an empty end marker
                  push_cmd.data  = 8'h00;
                  push_cmd.last  = 1'b1;
                  push_cmd.empty = 1'b1;
                  mode_in        = MODE_HUNT;
                  count_in       = '0;
               end else if (count_inc >= frame_len_ff) begin
                  push_cmd.last = 1'b1;
                  mode_in       = MODE_HUNT;
                  count_in      = '0;
               end
            end
            default: begin
               mode_in  = MODE_HUNT;
               count_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_HUNT;
         count_ff     <= '0;
         first_ff     <= '0;
         second_ff    <= '0;
         third_ff     <= '0;
         len_low_ff   <= '0;
         frame_len_ff <= '0;
         max_len_ff   <= MAX_CAM_LEN_RST;
      end else begin
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         third_ff     <= third_in;
         len_low_ff   <= len_low_in;
         frame_len_ff <= frame_len_in;
         max_len_ff   <= max_len_in;
      end
   end

endmodule

/* rtl/rsdf_queue.sv */
// small command queue between the parser and the output sequencer
module rsdf_queue #(
   parameter int Depth = rsdf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rsdf_pkg::cmd_type push_cmd,
   input  logic              pop,
   output rsdf_pkg::cmd_type head_cmd,
   output logic              full,
   output logic              empty
);
   import rsdf_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   cmd_type          entries_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CntW'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/rsdf_back.sv */
// output sequencer: expands header commands and drives the result register
module rsdf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  rsdf_pkg::cmd_type head_cmd,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_frame_kind,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last_byte,
   output logic              rsp_empty_frame
);
   import rsdf_pkg::*;

   logic       valid_ff, valid_in;
   logic       kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       empty_ff, empty_in;
   logic [1:0] step_ff, step_in;
   logic       load, issue;

   assign load  = !valid_ff || !rsp_stall;
   assign issue = load && !q_empty;

   always_comb begin
      valid_in = valid_ff;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      empty_in = empty_ff;
      step_in  = step_ff;
      pop      = 1'b0;
      if (issue) begin
         valid_in = 1'b1;
         kind_in  = head_cmd.frame_kind;
         byte_in  = head_cmd.data;
         last_in  = head_cmd.last;
         empty_in = head_cmd.empty;
         if (head_cmd.op == CMD_DISP_HDR) begin
            // header goes out as sync0, sync1, length
            last_in  = 1'b0;
            empty_in = 1'b0;
            case (step_ff)
               2'd0:    byte_in = DISP_SYNC0;
               2'd1:    byte_in = DISP_SYNC1;
               default: byte_in = head_cmd.data;
            endcase
            if (step_ff == 2'd2) begin
               step_in = '0;
               pop     = 1'b1;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end else begin
            pop = 1'b1;
         end
      end else if (load) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      empty_ff <= empty_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_frame_kind  = kind_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_byte   = last_ff;
   assign rsp_empty_frame = empty_ff;

endmodule

/* tb/sv/rs485_dual_frame_deframer_tb.sv */
// dual frame deframer testbench: directed and random bytes checked against a built-in parser
`timescale 1ns / 100ps

module rs485_dual_frame_deframer_tb;
   import rsdf_pkg::*;

   localparam int CYCLE_LIMIT      = 300000;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int PRINT_LIMIT      = 40;

   typedef enum logic [2:0] {
      HUNT_HEADER  = 3'b001,
      DISPLAY_BODY = 3'b010,
      CAMERA_BODY  = 3'b100
   } rx_state_type;

   typedef enum logic [1:0] {
      RX_FREE,
      RX_SPARSE,
      RX_PERIODIC,
      RX_HEAVY
   } stall_pattern_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic       last;
      logic       empty;
   } deframed_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_frame_kind;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_byte;
   logic        rsp_empty_frame;
   logic        csr_write_en = 1'b0;
   logic [15:0] csr_write_data = 16'h0000;

   // parser state mirrored from the block
   rx_state_type rx_state = HUNT_HEADER;
   logic [15:0] seen_count = 16'd0;
   logic [7:0]  hdr_byte0 = 8'd0;
   logic [7:0]  hdr_byte1 = 8'd0;
   logic [7:0]  hdr_byte2 = 8'd0;
   logic [7:0]  len_low = 8'd0;
   logic [15:0] frame_len = 16'd0;
   logic [15:0] cam_len_limit = MAX_CAM_LEN_RST;

   logic [7:0]        tx_bytes[$];
   deframed_word_type awaited_words[$];
   deframed_word_type want;

   int  bytes_queued = 0;
   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  burst_left = 0;
   int  gap_left = 0;
   bit  sender_dense = 1'b0;
   int  long_hold_reqs = 0;
   int  holds_served = 0;
   int  hold_left = 0;
   int  stretch_left = 0;
   stall_pattern_type stall_mode = RX_FREE;

   rs485_dual_frame_deframer uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_kind  (rsp_frame_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_byte   (rsp_last_byte),
      .rsp_empty_frame (rsp_empty_frame),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int exp_val);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("mismatch on %s: got 0x%0h, wanted 0x%0h (cycle %0d)",
                  what, got, exp_val, cycle_count);
      end
      mismatch_count++;
   endtask

   task automatic push_word(input logic kind, input logic [7:0] data,
                            input logic last, input logic empty);
      deframed_word_type w;
      w.kind  = kind;
      w.data  = data;
      w.last  = last;
      w.empty = empty;
      awaited_words.push_back(w);
   endtask

   task automatic restart_hunt();
      rx_state   = HUNT_HEADER;
      seen_count = 16'd0;
   endtask

   // works out the words one accepted byte causes
   task automatic parse_rx_byte(input logic [7:0] b);
      if (rx_state == HUNT_HEADER) begin
         seen_count = seen_count + 16'd1;
         case (seen_count)
            16'd1: begin
               hdr_byte0 = b;
               if (b != DISP_SYNC0 && b != CAM_SYNC0) restart_hunt();
            end
            16'd2: begin
               hdr_byte1 = b;
               if (b != DISP_SYNC1 && b != CAM_SYNC0) restart_hunt();
            end
            16'd3: begin
               hdr_byte2 = b;
               if (hdr_byte0 == DISP_SYNC0 && hdr_byte1 == DISP_SYNC1) begin
                  frame_len = {8'd0, b};
                  rx_state  = DISPLAY_BODY;
                  push_word(KIND_DISPLAY, DISP_SYNC0, 1'b0, 1'b0);
                  push_word(KIND_DISPLAY, DISP_SYNC1, 1'b0, 1'b0);
                  push_word(KIND_DISPLAY, b, 1'b0, 1'b0);
               end else if (hdr_byte0 != CAM_SYNC0) begin
                  restart_hunt();
               end
            end
            16'd6: len_low = b;
            16'd7: frame_len = {b, len_low};
            16'd8: begin
               if (hdr_byte0 == CAM_SYNC0 && hdr_byte1 == CAM_SYNC0 && hdr_byte2 == CAM_SYNC2
                   && frame_len <= cam_len_limit) begin
                  rx_state   = CAMERA_BODY;
                  seen_count = 16'd0;
               end else begin
                  restart_hunt();
               end
            end
            default: ;
         endcase
      end else if (rx_state == DISPLAY_BODY) begin
         seen_count = seen_count + 16'd1;
         // header bytes count toward the frame total
         if ({1'b0, seen_count} >= {1'b0, frame_len} + 17'd3) begin
            push_word(KIND_DISPLAY, b, 1'b1, 1'b0);
            restart_hunt();
         end else begin
            push_word(KIND_DISPLAY, b, 1'b0, 1'b0);
         end
      end else if (rx_state == CAMERA_BODY) begin
         seen_count = seen_count + 16'd1;
         if (frame_len == 16'd0) begin
            push_word(KIND_CAMERA, 8'h00, 1'b1, 1'b1);
            restart_hunt();
         end else if (seen_count >= frame_len) begin
            push_word(KIND_CAMERA, b, 1'b1, 1'b0);
            restart_hunt();
         end else begin
            push_word(KIND_CAMERA, b, 1'b0, 1'b0);
         end
      end else begin
         restart_hunt();
      end
   endtask

   // sender: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall) parse_rx_byte(req_rx_byte);
         if (!req_valid || !req_stall) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (gap_left > 0 && !sender_dense) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (tx_bytes.size() > 0) begin
               req_valid   <= 1'b1;
               req_rx_byte <= tx_bytes.pop_front();
               burst_left--;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each word, stalls on changing patterns
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_words.size() == 0) begin
               report_mismatch("word with none awaited, out_byte", rsp_out_byte, 0);
            end else begin
               want = awaited_words.pop_front();
               if (rsp_frame_kind != want.kind)
                  report_mismatch("frame_kind", rsp_frame_kind, want.kind);
               if (rsp_out_byte != want.data)
                  report_mismatch("out_byte", rsp_out_byte, want.data);
               if (rsp_last_byte != want.last)
                  report_mismatch("last_byte", rsp_last_byte, want.last);
               if (rsp_empty_frame != want.empty)
                  report_mismatch("empty_frame", rsp_empty_frame, want.empty);
            end
         end
         if (holds_served < long_hold_reqs) begin
            hold_left = LONG_HOLD_CYCLES;
            holds_served++;
         end
         if (stretch_left == 0) begin
            stall_mode   = stall_pattern_type'($urandom_range(0, 3));
            stretch_left = $urandom_range(10, 60);
         end else begin
            stretch_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               RX_FREE:     rsp_stall <= 1'b0;
               RX_SPARSE:   rsp_stall <= ($urandom_range(0, 2) == 0);
               RX_PERIODIC: rsp_stall <= (stretch_left % 3 == 0);
               default:     rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycle_count, awaited_words.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic queue_byte(input logic [7:0] b);
      tx_bytes.push_back(b);
      bytes_queued++;
   endtask

   // a byte that can never open a header
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom); while (b == DISP_SYNC0 || b == CAM_SYNC0);
      return b;
   endfunction

   task automatic add_display_frame(input int len);
      queue_byte(DISP_SYNC0);
      queue_byte(DISP_SYNC1);
      queue_byte(8'(len));
      repeat ((len == 0) ? 1 : len) queue_byte(8'($urandom));
   endtask

   task automatic add_camera_header(input logic [7:0] third, input logic [15:0] len);
      queue_byte(CAM_SYNC0);
      queue_byte(CAM_SYNC0);
      queue_byte(third);
      queue_byte(8'($urandom));
      queue_byte(8'($urandom));
      queue_byte(len[7:0]);
      queue_byte(len[15:8]);
      queue_byte(8'($urandom));
   endtask

   task automatic add_camera_frame(input logic [15:0] len);
      add_camera_header(CAM_SYNC2, len);
      // a zero length frame still consumes one byte
      if (len <= cam_len_limit) repeat ((len == 0) ? 1 : int'(len)) queue_byte(8'($urandom));
   endtask

   // broken sequences, each leaves the parser hunting from scratch
   task automatic add_noise();
      logic [7:0] b;
      case ($urandom_range(0, 3))
         0: repeat ($urandom_range(1, 3)) queue_byte(plain_byte());
         1: begin
            queue_byte(DISP_SYNC0);
            do b = plain_byte(); while (b == DISP_SYNC1);
            queue_byte(b);
         end
         2: begin
            do b = 8'($urandom); while (b == CAM_SYNC2);
            add_camera_header(b, 16'($urandom));
         end
         default: begin
            queue_byte(CAM_SYNC0);
            queue_byte(DISP_SYNC1);
            repeat (6) queue_byte(8'($urandom));
         end
      endcase
   endtask

   function automatic logic [15:0] pick_camera_len();
      int lim;
      lim = cam_len_limit;
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return (lim <= 64) ? 16'(lim) : 16'($urandom_range(1, 12));
         2: return (lim < 65535) ? 16'(lim + 1) : 16'($urandom_range(1, 12));
         3: return (lim < 65535) ? 16'($urandom_range(lim + 1, 65535))
                                 : 16'($urandom_range(1, 12));
         default: return 16'($urandom_range(1, (lim < 12) ? lim : 12));
      endcase
   endfunction

   task automatic random_traffic(input int n_bytes);
      int goal;
      goal = bytes_queued + n_bytes;
      while (bytes_queued < goal) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               if ($urandom_range(0, 11) == 0) add_display_frame($urandom_range(11, 40));
               else add_display_frame($urandom_range(0, 10));
            end
            4, 5, 6, 7: add_camera_frame(pick_camera_len());
            default: add_noise();
         endcase
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (tx_bytes.size() != 0 || req_valid || awaited_words.size() != 0)
         @(negedge clock);
   endtask

   // register writes only with the block idle
   task automatic write_cam_limit(input logic [15:0] value);
      wait_drained();
      repeat (8) @(negedge clock);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en  <= 1'b0;
      cam_len_limit = value;
      @(negedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: bad first, second and third bytes, shortest display frame,
      // zero length camera frame, oversized camera length
      queue_byte(8'hFF);
      queue_byte(DISP_SYNC0);
      queue_byte(8'h00);
      queue_byte(DISP_SYNC0);
      queue_byte(CAM_SYNC0);
      queue_byte(8'h00);
      add_display_frame(0);
      add_camera_frame(16'd0);
      add_camera_frame(16'hFFFF);
      wait_drained();

      // long receiver hold with the sender offering every cycle
      sender_dense = 1'b1;
      long_hold_reqs++;
      repeat (6) add_display_frame($urandom_range(2, 6));
      wait_drained();
      sender_dense = 1'b0;
      random_traffic(12);
      wait_drained();
      random_traffic(12);

      write_cam_limit(16'd1);
      random_traffic(16);

      write_cam_limit(16'hFFFF);
      add_camera_frame(16'd20);
      add_display_frame(20);
      random_traffic(12);

      write_cam_limit(16'd37);
      long_hold_reqs++;
      random_traffic(16);

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/rsdf_pkg.sv
rtl/rsdf_front.sv
rtl/rsdf_queue.sv
rtl/rsdf_back.sv
rtl/rs485_dual_frame_deframer.sv
tb/sv/rs485_dual_frame_deframer_tb.sv
